// File: rtl/fppi_pkg.sv
// ----------------------------------------------------------------------------
// fppi_pkg
// Shared types and constants for the fixed-point PI controller.
// ----------------------------------------------------------------------------
package fppi_pkg;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned EDT_W   = 24;
  localparam int unsigned MUL_A_W = 25;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic signed [DATA_W:0] INTEG_MAX   = 17'sd32767;
  localparam logic signed [DATA_W:0] INTEG_MIN   = -17'sd32768;
  localparam logic signed [DATA_W:0] DRIVE_LIMIT = 17'sd32640;

  // Multiplier operand selection codes.
  localparam logic [1:0] MUL_OP_P = 2'd0;
  localparam logic [1:0] MUL_OP_E = 2'd1;
  localparam logic [1:0] MUL_OP_I = 2'd2;

  // Configuration register indexes.
  localparam logic REG_PROP_GAIN     = 1'b0;
  localparam logic REG_INTEGRAL_GAIN = 1'b1;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_op;
    logic       finish;
  } dp_cmd_t;

endpackage

// File: rtl/fppi_ctrl.sv
// ----------------------------------------------------------------------------
// fppi_ctrl
// Sequencer for one controller update: three multiplies, then accumulate.
// ----------------------------------------------------------------------------
module fppi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output fppi_pkg::dp_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL_P = 3'd1;
  localparam logic [2:0] ST_MUL_E = 3'd2;
  localparam logic [2:0] ST_MUL_I = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.mul_op = fppi_pkg::MUL_OP_P;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = fppi_pkg::MUL_OP_P;
        state_nxt  = ST_MUL_E;
      end
      ST_MUL_E: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = fppi_pkg::MUL_OP_E;
        state_nxt  = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = fppi_pkg::MUL_OP_I;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        // The output register must be free or emptying this cycle.
        if (!out_valid_r || out_tready) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// File: rtl/fppi_dp.sv
// ----------------------------------------------------------------------------
// fppi_dp
// Datapath: error and elapsed time, one shared signed multiplier, the
// saturating integrator and the clamped output register.
// ----------------------------------------------------------------------------
module fppi_dp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  fppi_pkg::dp_cmd_t                       cmd,
  input  logic signed [fppi_pkg::DATA_W-1:0]      setpoint,
  input  logic signed [fppi_pkg::DATA_W-1:0]      measured,
  input  logic        [fppi_pkg::TIME_W-1:0]      now_us,
  input  logic signed [fppi_pkg::DATA_W-1:0]      prop_gain,
  input  logic signed [fppi_pkg::DATA_W-1:0]      integral_gain,
  output logic signed [fppi_pkg::DATA_W-1:0]      drive
);

  localparam int unsigned DW  = fppi_pkg::DATA_W;
  localparam int unsigned MAW = fppi_pkg::MUL_A_W;
  localparam int unsigned MBW = fppi_pkg::MUL_B_W;

  logic signed [DW-1:0]                     err_r;
  logic        [DW-1:0]                     dt_r;
  logic        [fppi_pkg::TIME_W-1:0]       prev_time_r;
  logic signed [DW-1:0]                     pterm_r;
  logic signed [fppi_pkg::EDT_W-1:0]        edt_r;
  logic signed [DW-1:0]                     inc_r;
  logic signed [DW-1:0]                     integ_r, integ_nxt;
  logic signed [DW-1:0]                     drive_r, drive_nxt;
  logic        [fppi_pkg::TIME_W-1:0]       elapsed;

  logic signed [fppi_pkg::MUL_A_W-1:0]      mul_a;
  logic signed [fppi_pkg::MUL_B_W-1:0]      mul_b;
  logic signed [fppi_pkg::MUL_P_W-1:0]      prod;

  logic signed [DW:0]                       acc, acc_sat, total, total_sat;

  assign elapsed = now_us - prev_time_r;

  always_comb begin
    case (cmd.mul_op)
      fppi_pkg::MUL_OP_P: begin
        mul_a = MAW'(prop_gain);
        mul_b = MBW'(err_r);
      end
      fppi_pkg::MUL_OP_E: begin
        mul_a = MAW'(err_r);
        mul_b = $signed({1'b0, dt_r});
      end
      fppi_pkg::MUL_OP_I: begin
        mul_a = MAW'(edt_r);
        mul_b = MBW'(integral_gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Both sums are 17 bits wide and their operands hold 16-bit values, so neither can wrap.
  always_comb begin
    acc = (DW+1)'(integ_r) + (DW+1)'(inc_r);
    if (acc > fppi_pkg::INTEG_MAX) begin
      acc_sat = fppi_pkg::INTEG_MAX;
    end else if (acc < fppi_pkg::INTEG_MIN) begin
      acc_sat = fppi_pkg::INTEG_MIN;
    end else begin
      acc_sat = acc;
    end
    total = (DW+1)'(pterm_r) + acc_sat;
    if (total > fppi_pkg::DRIVE_LIMIT) begin
      total_sat = fppi_pkg::DRIVE_LIMIT;
    end else if (total < -fppi_pkg::DRIVE_LIMIT) begin
      total_sat = -fppi_pkg::DRIVE_LIMIT;
    end else begin
      total_sat = total;
    end
    integ_nxt = acc_sat[DW-1:0];
    drive_nxt = total_sat[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_time_r <= '0;
      integ_r     <= '0;
    end else begin
      if (cmd.load) begin
        prev_time_r <= now_us;
      end
      if (cmd.finish) begin
        integ_r <= integ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err_r <= setpoint - measured;
      dt_r  <= elapsed[DW-1:0];
    end
    if (cmd.mul_en) begin
      case (cmd.mul_op)
        fppi_pkg::MUL_OP_P: pterm_r <= prod[DW+7:8];
        fppi_pkg::MUL_OP_E: edt_r   <= prod[fppi_pkg::EDT_W+7:8];
        fppi_pkg::MUL_OP_I: inc_r   <= prod[DW+15:16];
        default: ;
      endcase
    end
    if (cmd.finish) begin
      drive_r <= drive_nxt;
    end
  end

  assign drive = drive_r;

endmodule

// File: rtl/fixed_point_pi_controller.sv
// ----------------------------------------------------------------------------
// fixed_point_pi_controller
// Fixed-point PI controller with a saturating integrator and an APB-style
// gain register port.
// ----------------------------------------------------------------------------
// Each input beat carries a setpoint, a measured value and a microsecond
// timestamp; each one produces exactly one drive beat. An update makes three
// passes through one shared 25x17 multiplier plus the accumulate step, and a
// new beat is accepted once the previous update has reached the output
// register; the accumulate step waits while that register still holds an
// unaccepted result. A finished result waiting on out_tready does not block
// the next beat from being accepted. Gains are Q8.8 and should be written
// while the block is idle.
module fixed_point_pi_controller (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // setpoint[15:0], measured[31:16], now_us[63:32]
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // drive[15:0]
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned DW = fppi_pkg::DATA_W;

  logic signed [DW-1:0] prop_gain_r;
  logic signed [DW-1:0] integral_gain_r;
  logic                 cfg_wr;
  logic                 cfg_idx;
  logic signed [DW-1:0] drive;
  fppi_pkg::dp_cmd_t    cmd;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r     <= 16'sd256;
      integral_gain_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        fppi_pkg::REG_PROP_GAIN:     prop_gain_r     <= cfg_pwdata[DW-1:0];
        fppi_pkg::REG_INTEGRAL_GAIN: integral_gain_r <= cfg_pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      fppi_pkg::REG_PROP_GAIN:     cfg_prdata = {16'd0, prop_gain_r};
      fppi_pkg::REG_INTEGRAL_GAIN: cfg_prdata = {16'd0, integral_gain_r};
      default:                     cfg_prdata = '0;
    endcase
  end

  fppi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  fppi_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .setpoint      (in_tdata[15:0]),
    .measured      (in_tdata[31:16]),
    .now_us        (in_tdata[63:32]),
    .prop_gain     (prop_gain_r),
    .integral_gain (integral_gain_r),
    .drive         (drive)
  );

  assign out_tdata = drive;

endmodule

// File: tb/pi_drive_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pi_drive_checker
// Watches the sample, drive and gain-register channels of the PI controller,
// predicts every drive beat from its own copy of the gains, timestamp and
// integrator, and compares the drive beats in order as they leave the block.
// ----------------------------------------------------------------------------
module pi_drive_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // setpoint[15:0], measured[31:16], now_us[63:32]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // drive[15:0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending
);

  logic signed [15:0] kp_q88;
  logic signed [15:0] ki_q88;
  logic        [31:0] last_stamp;
  logic signed [15:0] integ_acc;
  logic        [15:0] drive_expected[$];
  logic        [15:0] want_drive;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] drive check: %s", $time, what);
    fail_count++;
  endtask

  // One controller update; advances the timestamp and the integrator.
  function automatic logic [15:0] advance_controller(logic signed [15:0] setpoint,
                                                     logic signed [15:0] measured,
                                                     logic        [31:0] now_us);
    logic signed [15:0] err;
    logic signed [15:0] pterm;
    logic signed [15:0] inc;
    logic        [15:0] dt16;
    longint e, dt, edt, acc, total;
    err   = setpoint - measured;
    e     = err;
    total = (longint'(kp_q88) * e) >>> 8;
    pterm = total[15:0];
    dt16  = 16'(now_us - last_stamp);
    dt    = dt16;
    last_stamp = now_us;
    edt   = (e * dt) >>> 8;
    acc   = (longint'(ki_q88) * edt) >>> 16;
    inc   = acc[15:0];
    acc   = longint'(integ_acc) + longint'(inc);
    if (acc > 32767) acc = 32767;
    else if (acc < -32768) acc = -32768;
    integ_acc = acc[15:0];
    total = longint'(pterm) + acc;
    if (total > 32640) total = 32640;
    else if (total < -32640) total = -32640;
    return total[15:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      kp_q88     = 16'sd256;
      ki_q88     = 16'sd0;
      last_stamp = '0;
      integ_acc  = '0;
      drive_expected.delete();
    end else begin
      // The drive leaving now always belongs to an older sample than one
      // entering in the same cycle.
      if (out_tvalid && out_tready) begin
        if (drive_expected.size() == 0) begin
          report_mismatch($sformatf("drive beat %0d with nothing expected",
                                    $signed(out_tdata)));
        end else begin
          want_drive = drive_expected.pop_front();
          if (out_tdata !== want_drive)
            report_mismatch($sformatf("drive got %0d expected %0d",
                                      $signed(out_tdata), $signed(want_drive)));
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[1:0] == 2'b00) begin
        if (cfg_paddr[2] == fppi_pkg::REG_PROP_GAIN) kp_q88 = cfg_pwdata[15:0];
        if (cfg_paddr[2] == fppi_pkg::REG_INTEGRAL_GAIN) ki_q88 = cfg_pwdata[15:0];
      end
      if (in_tvalid && in_tready)
        drive_expected.push_back(advance_controller(in_tdata[15:0], in_tdata[31:16],
                                                    in_tdata[63:32]));
    end
    pending <= drive_expected.size();
  end

endmodule

// File: tb/fixed_point_pi_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_pi_controller_test
// Drives directed and random samples through the PI controller under several
// gain settings, with bursty input, a stalling receiver and one long output
// hold-off; the checker beside the block predicts and compares every drive.
// ----------------------------------------------------------------------------
module fixed_point_pi_controller_test;

  localparam int IDLE_LIMIT  = 3000;
  localparam int PHASE_BEATS = 225;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // setpoint[15:0], measured[31:16], now_us[63:32]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // drive[15:0]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int          fail_count;
  int          pending;
  int          hold_cycles;
  int          burst_left;
  logic [31:0] stamp_us;

  fixed_point_pi_controller u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  pi_drive_checker u_drive_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_pready (cfg_pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offers one sample and holds it until accepted; ends on a falling edge.
  // The sender runs in bursts with idle gaps between them.
  task automatic send_sample(input logic [15:0] setpoint, input logic [15:0] measured,
                             input logic [31:0] now_us);
    in_tvalid <= 1'b1;
    in_tdata  <= {now_us, measured, setpoint};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
    end
  endtask

  // Waits until every drive beat has come back, then lets the pipeline settle.
  task automatic drain(input int settle);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_gain(input logic reg_index, input logic [15:0] gain);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {reg_index, 2'b00};
    cfg_pwdata  <= {{16{gain[15]}}, gain};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic logic [15:0] pick_gain(input bit narrow);
    if (narrow) return 16'($urandom_range(0, 1200)) - 16'd600;
    return 16'($urandom);
  endfunction

  // Mostly small errors and ordinary sample spacing, with full-range values,
  // long gaps, counter wraps and backward steps mixed in.
  task automatic send_random();
    logic [15:0] setpoint;
    logic [15:0] measured;
    int          pick;
    setpoint = 16'($urandom);
    if ($urandom_range(0, 9) < 6) measured = setpoint + 16'($urandom_range(0, 600)) - 16'd300;
    else measured = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 70) stamp_us = stamp_us + $urandom_range(1, 3000);
    else if (pick < 85) stamp_us = stamp_us + $urandom_range(0, 65535);
    else if (pick < 92) stamp_us = stamp_us + $urandom_range(65536, 200000);
    else if (pick < 97) stamp_us = $urandom;
    else stamp_us = stamp_us - $urandom_range(1, 5000);
    send_sample(setpoint, measured, stamp_us);
  endtask

  // Receiver: switches between stall patterns, and honors a long hold-off.
  initial begin
    int stall_mode;
    int mode_left;
    int cyc;
    out_tready = 1'b0;
    stall_mode = 0;
    mode_left  = 50;
    cyc        = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else begin
        case (stall_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (cyc % 7) < 4;
        endcase
      end
      mode_left--;
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 120);
      end
    end
  end

  // Watchdog on cycles with no beat and no register write.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready))
        idle = 0;
      else
        idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    hold_cycles = 0;
    burst_left  = 4;
    stamp_us    = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset gains; the first sample measures its interval from zero.
    stamp_us = 32'd1500;
    send_sample(16'sd100, 16'sd40, stamp_us);
    stamp_us += 100;
    send_sample(16'h7FFF, 16'h8000, stamp_us);
    stamp_us += 100;
    send_sample(16'h8000, 16'h7FFF, stamp_us);
    send_sample(16'h0000, 16'h0000, stamp_us);
    drain(8);

    // Largest positive gains: overflowing terms and integrator saturation.
    write_gain(fppi_pkg::REG_PROP_GAIN, 16'h7FFF);
    write_gain(fppi_pkg::REG_INTEGRAL_GAIN, 16'h7FFF);
    stamp_us += 65535;
    send_sample(16'h7FFF, 16'h0000, stamp_us);
    stamp_us += 65535;
    send_sample(16'h7FFF, 16'h0000, stamp_us);
    stamp_us += 70000;
    send_sample(16'h8000, 16'h0000, stamp_us);
    stamp_us += 65535;
    send_sample(16'h8000, 16'h0000, stamp_us);
    stamp_us += 65535;
    send_sample(16'h8000, 16'h0000, stamp_us);
    stamp_us -= 10;
    send_sample(16'sd200, 16'sd100, stamp_us);
    drain(8);

    // Most negative gains, and the microsecond counter wrapping.
    write_gain(fppi_pkg::REG_PROP_GAIN, 16'h8000);
    write_gain(fppi_pkg::REG_INTEGRAL_GAIN, 16'h8000);
    stamp_us += 1;
    send_sample(16'h7FFF, 16'h8000, stamp_us);
    stamp_us = 32'hFFFF_FFF0;
    send_sample(16'sd1, 16'sd0, stamp_us);
    stamp_us = 32'h0000_0010;
    send_sample(16'sd1, 16'sd0, stamp_us);
    stamp_us += 40000;
    send_sample(16'hFFFF, 16'h0000, stamp_us);
    stamp_us += 1000;
    send_sample(16'h7FFF, 16'h7FFF, stamp_us);
    drain(8);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_gain(fppi_pkg::REG_PROP_GAIN, 16'sd256);
          write_gain(fppi_pkg::REG_INTEGRAL_GAIN, 16'sd64);
        end
        1: begin
          write_gain(fppi_pkg::REG_PROP_GAIN, 16'h8000);
          write_gain(fppi_pkg::REG_INTEGRAL_GAIN, 16'h7FFF);
        end
        2: begin
          write_gain(fppi_pkg::REG_PROP_GAIN, 16'h0000);
          write_gain(fppi_pkg::REG_INTEGRAL_GAIN, 16'h0000);
        end
        default: begin
          write_gain(fppi_pkg::REG_PROP_GAIN, pick_gain(1'($urandom_range(0, 1))));
          write_gain(fppi_pkg::REG_INTEGRAL_GAIN, pick_gain(1'($urandom_range(0, 1))));
        end
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // The receiver holds off while samples keep coming, so the block backs up.
        if (phase == 3 && n == 60) hold_cycles = 400;
        send_random();
      end
      drain(8);
    end

    drain(30);
    if (fail_count == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: files.f
rtl/fppi_pkg.sv
rtl/fppi_ctrl.sv
rtl/fppi_dp.sv
rtl/fixed_point_pi_controller.sv
tb/pi_drive_checker.sv
tb/fixed_point_pi_controller_test.sv
